[sv/fsync_pkg.sv]
`timescale 1ns / 1ps

package fsync_pkg;

	// Field widths fixed by the stream format and the register map.
	localparam int SAMPLE_W   = 16;
	localparam int DIST_W     = 7;
	localparam int SLEN_W     = 7;
	localparam int HITS_W     = 8;
	localparam int FLEN_W     = 16;
	localparam int SINCE_W    = 17;
	localparam int PHASE_W    = 2;
	localparam int SYNC_W     = 64;

	// Saturation limits of the hit counters and of the sample distance counter.
	localparam logic [HITS_W-1:0]  HITS_MAX  = 8'hFF;
	localparam logic [SINCE_W-1:0] SINCE_MAX = 17'h1FFFF;

	// Decoupling queue between the correlator and the lock tracker.
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int QCNT_W      = 4;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MARKER         = 3'd0,
		REG_SYNC_LENGTH    = 3'd1,
		REG_SEARCH_TO_LOCK = 3'd2,
		REG_LOCK_TO_SEARCH = 3'd3,
		REG_SLIP_BITS      = 3'd4,
		REG_FRAME_LENGTH   = 3'd5
	} reg_index_t;

	// Phase codes of the four marker forms.
	typedef enum logic [1:0] {
		PHASE_0   = 2'd0,
		PHASE_90  = 2'd1,
		PHASE_180 = 2'd2,
		PHASE_270 = 2'd3
	} phase_t;

	// One classified sample as handed from the correlator to the lock tracker.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [DIST_W-1:0]   best;
		logic [PHASE_W-1:0]  phase;
	} fsync_entry_t;

endpackage

[sv/frame_sync_with_phase_ambiguity.sv]
`timescale 1ns / 1ps

// Path: each sample passes the correlator stages and the queue into the output register.
// Throughput: one sample per clock; the correlator pipe and the lock tracker both run at that rate.
// An eight-entry queue decouples them, so input is held off only when the output is stalled.
// Reset: asynchronous, active low; config registers reset to defaults, window and lock state clear.
// No clearing pass follows reset; the first sample can be accepted on the next edge.

module frame_sync_with_phase_ambiguity #(
	parameter int WINDOW_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// Sample input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] soft_sample
	// Sample output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample_out
	output logic [3:0]  m_axis_tuser    // [0] tag_valid, [2:1] tag_phase, [3] locked
);

	logic [fsync_pkg::SYNC_W-1:0]       marker_q;
	logic [fsync_pkg::SLEN_W-1:0]       sync_length_q;
	logic [fsync_pkg::HITS_W-1:0]       search_to_lock_q;
	logic [fsync_pkg::HITS_W-1:0]       lock_to_search_q;
	logic [fsync_pkg::SLEN_W-1:0]       slip_bits_q;
	logic [fsync_pkg::FLEN_W-1:0]       frame_length_q;

	logic                               push;
	fsync_pkg::fsync_entry_t            push_entry;
	logic                               pop;
	logic                               head_valid;
	fsync_pkg::fsync_entry_t            head;
	logic [fsync_pkg::QCNT_W-1:0]       q_level;
	logic                               tag_valid;
	logic [fsync_pkg::PHASE_W-1:0]      tag_phase;
	logic                               locked;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q         <= '0;
			sync_length_q    <= 7'd32;
			search_to_lock_q <= 8'd2;
			lock_to_search_q <= 8'd2;
			slip_bits_q      <= '0;
			frame_length_q   <= 16'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				fsync_pkg::REG_MARKER:
					marker_q         <= cfg_data;
				fsync_pkg::REG_SYNC_LENGTH:
					sync_length_q    <= cfg_data[fsync_pkg::SLEN_W-1:0];
				fsync_pkg::REG_SEARCH_TO_LOCK:
					search_to_lock_q <= cfg_data[fsync_pkg::HITS_W-1:0];
				fsync_pkg::REG_LOCK_TO_SEARCH:
					lock_to_search_q <= cfg_data[fsync_pkg::HITS_W-1:0];
				fsync_pkg::REG_SLIP_BITS:
					slip_bits_q      <= cfg_data[fsync_pkg::SLEN_W-1:0];
				fsync_pkg::REG_FRAME_LENGTH:
					frame_length_q   <= cfg_data[fsync_pkg::FLEN_W-1:0];
				default:
					marker_q         <= marker_q;
			endcase
		end
	end

	// Correlator: window, distance pipe and phase selection.
	fsync_front #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.marker_bits (marker_q),
		.sync_length (sync_length_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata),
		.q_level     (q_level),
		.push        (push),
		.push_entry  (push_entry)
	);

	// Queue between correlator and lock tracker.
	fsync_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.level      (q_level)
	);

	// Lock tracker and output register.
	fsync_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.search_to_lock (search_to_lock_q),
		.lock_to_search (lock_to_search_q),
		.slip_bits      (slip_bits_q),
		.frame_length   (frame_length_q),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.sample_out     (m_axis_tdata),
		.tag_valid      (tag_valid),
		.tag_phase      (tag_phase),
		.locked         (locked)
	);

	assign m_axis_tuser = {locked, tag_phase, tag_valid};

endmodule

[sv/fsync_front.sv]
`timescale 1ns / 1ps

module fsync_front #(
	parameter int WINDOW_BITS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [fsync_pkg::SYNC_W-1:0]          marker_bits,
	input  logic [fsync_pkg::SLEN_W-1:0]          sync_length,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [fsync_pkg::SAMPLE_W-1:0]        in_sample,
	input  logic [fsync_pkg::QCNT_W-1:0]          q_level,
	output logic                                  push,
	output fsync_pkg::fsync_entry_t               push_entry
);

	localparam int NCHUNK = (WINDOW_BITS + 7) / 8;
	localparam int PAD_W  = NCHUNK * 8;
	localparam int DW     = $clog2(WINDOW_BITS + 1);
	localparam int CW     = 4;
	localparam int LVL_W  = fsync_pkg::QCNT_W + 1;

	logic                                 accept;
	logic [WINDOW_BITS-1:0]               window_q;

	logic                                 v1_q;
	logic [fsync_pkg::SAMPLE_W-1:0]       sample_s1;
	logic [WINDOW_BITS-1:0]               win_s1;

	logic                                 v2_q;
	logic [fsync_pkg::SAMPLE_W-1:0]       sample_s2;
	logic [3:0][NCHUNK-1:0][CW-1:0]       cnt_s2;

	logic                                 v3_q;
	logic [fsync_pkg::SAMPLE_W-1:0]       sample_s3;
	logic [3:0][DW-1:0]                   dist_s3;

	logic [fsync_pkg::SLEN_W-1:0]         len;
	logic [WINDOW_BITS-1:0]               mask;
	logic [3:0][WINDOW_BITS-1:0]          code;
	logic [3:0][NCHUNK-1:0][CW-1:0]       cnt_c;
	logic [3:0][DW-1:0]                   dist_c;
	logic [DW-1:0]                        best_c;
	logic [1:0]                           phase_c;
	logic [LVL_W-1:0]                     occupancy;

	// Admission: queue entries plus items still in the pipe must leave room.
	assign occupancy = LVL_W'(q_level) + LVL_W'(v1_q) + LVL_W'(v2_q) + LVL_W'(v3_q);
	assign in_ready  = occupancy < LVL_W'(fsync_pkg::QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	// Hard decision window; the correlator sees it before the new bit enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (accept) begin
			window_q <= {window_q[WINDOW_BITS-2:0], ~in_sample[fsync_pkg::SAMPLE_W-1]};
		end
	end

	// Valid bits of the correlator pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= accept;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// Stage 1 captures the sample and the window that precedes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_sample;
			win_s1    <= window_q;
		end
	end

	// Pattern mask and the four phase forms of the sync word.
	always_comb begin
		logic [WINDOW_BITS-1:0] sw;
		logic [WINDOW_BITS-1:0] sw_lo;
		logic [WINDOW_BITS-1:0] sw_hi;
		logic                   take_low;
		logic                   src;
		sw    = marker_bits[WINDOW_BITS-1:0];
		sw_lo = {sw[WINDOW_BITS-2:0], sw[0]};
		sw_hi = {1'b0, sw[WINDOW_BITS-1:1]};
		len   = (sync_length > fsync_pkg::SLEN_W'(WINDOW_BITS)) ?
			fsync_pkg::SLEN_W'(WINDOW_BITS) : sync_length;
		code[fsync_pkg::PHASE_0]   = sw;
		code[fsync_pkg::PHASE_180] = ~sw;
		code[fsync_pkg::PHASE_90]  = '0;
		code[fsync_pkg::PHASE_270] = '0;
		mask                       = '0;
		for (int p = 0; p < WINDOW_BITS; p++) begin
			mask[p] = fsync_pkg::SLEN_W'(p) < len;
			// The partner of a pattern bit sits one position below or above,
			// depending on the parity of the position and of the length.
			// The lowest bit of an odd pattern has no partner and keeps its own.
			take_low = ((p % 2) == 1) ^ len[0];
			if (take_low) begin
				src = sw_lo[p];
				code[fsync_pkg::PHASE_90][p]  = ~src;
				code[fsync_pkg::PHASE_270][p] = src;
			end else begin
				src = sw_hi[p];
				code[fsync_pkg::PHASE_90][p]  = src;
				code[fsync_pkg::PHASE_270][p] = ~src;
			end
		end
	end

	// Per-byte mismatch counts for each phase form.
	always_comb begin
		logic [PAD_W-1:0] diff;
		for (int k = 0; k < 4; k++) begin
			diff = PAD_W'((win_s1 ^ code[k]) & mask);
			for (int c = 0; c < NCHUNK; c++) begin
				cnt_c[k][c] = '0;
				for (int b = 0; b < 8; b++) begin
					cnt_c[k][c] = cnt_c[k][c] + CW'(diff[c*8+b]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q) begin
			sample_s2 <= sample_s1;
			cnt_s2    <= cnt_c;
		end
	end

	// Stage 3 sums the byte counts into full Hamming distances.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dist_c[k] = '0;
			for (int c = 0; c < NCHUNK; c++) begin
				dist_c[k] = dist_c[k] + DW'(cnt_s2[k][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v2_q) begin
			sample_s3 <= sample_s2;
			dist_s3   <= dist_c;
		end
	end

	// Minimum distance; on a tie the lower phase wins.
	always_comb begin
		best_c  = dist_s3[fsync_pkg::PHASE_0];
		phase_c = fsync_pkg::PHASE_0;
		for (int k = 1; k < 4; k++) begin
			if (dist_s3[k] < best_c) begin
				best_c  = dist_s3[k];
				phase_c = 2'(k);
			end
		end
	end

	assign push              = v3_q;
	assign push_entry.sample = sample_s3;
	assign push_entry.best   = fsync_pkg::DIST_W'(best_c);
	assign push_entry.phase  = phase_c;

endmodule

[sv/fsync_queue.sv]
`timescale 1ns / 1ps

module fsync_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  fsync_pkg::fsync_entry_t            push_entry,
	input  logic                               pop,
	output logic                               head_valid,
	output fsync_pkg::fsync_entry_t            head,
	output logic [fsync_pkg::QCNT_W-1:0]       level
);

	fsync_pkg::fsync_entry_t               store_q [fsync_pkg::QUEUE_DEPTH];
	logic [fsync_pkg::QPTR_W-1:0]          wr_q;
	logic [fsync_pkg::QPTR_W-1:0]          rd_q;
	logic [fsync_pkg::QCNT_W-1:0]          level_q;

	// Entry storage; the writer never overruns thanks to admission control.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign head_valid = level_q != '0;
	assign head       = store_q[rd_q];
	assign level      = level_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (level_q < fsync_pkg::QCNT_W'(fsync_pkg::QUEUE_DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("queue read while empty");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level_q == $past(level_q) + 1'b1))
		else $error("queue level did not follow a lone write");

endmodule

[sv/fsync_back.sv]
`timescale 1ns / 1ps

module fsync_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fsync_pkg::HITS_W-1:0]        search_to_lock,
	input  logic [fsync_pkg::HITS_W-1:0]        lock_to_search,
	input  logic [fsync_pkg::SLEN_W-1:0]        slip_bits,
	input  logic [fsync_pkg::FLEN_W-1:0]        frame_length,
	input  logic                                head_valid,
	input  fsync_pkg::fsync_entry_t             head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fsync_pkg::SAMPLE_W-1:0]      sample_out,
	output logic                                tag_valid,
	output logic [fsync_pkg::PHASE_W-1:0]       tag_phase,
	output logic                                locked
);

	logic                                lock_q;
	logic [fsync_pkg::PHASE_W-1:0]       phase_q;
	logic [fsync_pkg::HITS_W-1:0]        good_q;
	logic [fsync_pkg::HITS_W-1:0]        bad_q;
	logic [fsync_pkg::SINCE_W-1:0]       since_q;
	logic [fsync_pkg::FLEN_W-1:0]        fphase_q;

	logic                                out_valid_q;
	logic [fsync_pkg::SAMPLE_W-1:0]      sample_q;
	logic                                tag_q;
	logic [fsync_pkg::PHASE_W-1:0]       tphase_q;
	logic                                locked_q;

	logic [fsync_pkg::FLEN_W-1:0]        flen;
	logic [fsync_pkg::SLEN_W-1:0]        threshold;
	logic                                hit;
	logic                                spaced;
	logic                                lock_n;
	logic [fsync_pkg::PHASE_W-1:0]       phase_n;
	logic [fsync_pkg::HITS_W-1:0]        good_n;
	logic [fsync_pkg::HITS_W-1:0]        bad_n;
	logic [fsync_pkg::SINCE_W-1:0]       since_n;
	logic [fsync_pkg::FLEN_W-1:0]        fphase_n;
	logic [fsync_pkg::SINCE_W-1:0]       fphase_inc;
	logic                                tag_n;

	// Take the next entry whenever the output register is free or draining.
	assign pop = head_valid && (!out_valid_q || out_ready);

	// Hit decision and spacing test against the previous hit.
	assign flen      = (frame_length == '0) ? fsync_pkg::FLEN_W'(1) : frame_length;
	assign threshold = lock_q ? slip_bits : '0;
	assign hit       = head.best <= threshold;
	assign spaced    = (since_q >= {1'b0, flen}) && (since_q < {flen, 1'b0});
	assign fphase_inc = {1'b0, fphase_q} + 1'b1;

	// Next lock tracking state for the entry at the head.
	always_comb begin
		logic lock_a;
		phase_n  = phase_q;
		good_n   = good_q;
		bad_n    = bad_q;
		lock_n   = lock_q;
		lock_a   = lock_q;
		if (hit) begin
			phase_n = head.phase;
			if (spaced) begin
				good_n = (good_q == fsync_pkg::HITS_MAX) ? good_q : good_q + 1'b1;
				bad_n  = '0;
			end else begin
				good_n = '0;
				bad_n  = (bad_q == fsync_pkg::HITS_MAX) ? bad_q : bad_q + 1'b1;
			end
			// Entering lock is tested first, then leaving it.
			lock_a = lock_q || (good_n >= search_to_lock);
			lock_n = lock_a && !(bad_n >= lock_to_search);
		end
		tag_n = lock_n && (hit || (fphase_q == '0));
		if (hit) begin
			since_n  = fsync_pkg::SINCE_W'(1);
			fphase_n = (flen == fsync_pkg::FLEN_W'(1)) ? '0 : fsync_pkg::FLEN_W'(1);
		end else begin
			since_n  = (since_q == fsync_pkg::SINCE_MAX) ? since_q : since_q + 1'b1;
			fphase_n = (fphase_inc >= {1'b0, flen}) ? '0 : fphase_inc[fsync_pkg::FLEN_W-1:0];
		end
	end

	// Lock tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q   <= 1'b0;
			phase_q  <= '0;
			good_q   <= '0;
			bad_q    <= '0;
			since_q  <= '0;
			fphase_q <= '0;
		end else if (pop) begin
			lock_q   <= lock_n;
			phase_q  <= phase_n;
			good_q   <= good_n;
			bad_q    <= bad_n;
			since_q  <= since_n;
			fphase_q <= fphase_n;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= head.sample;
			tag_q    <= tag_n;
			tphase_q <= tag_n ? phase_n : '0;
			locked_q <= lock_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign tag_valid  = tag_q;
	assign tag_phase  = tphase_q;
	assign locked     = locked_q;

	a_tag_needs_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tag_q) |-> locked_q)
		else $error("tag issued while not locked");

	a_phase_only_on_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tag_q) |-> (tphase_q == '0))
		else $error("tag phase set without a tag");

	a_pop_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && (locked_q == lock_q)))
		else $error("popped entry did not reach the output register");

endmodule
